[hdl/acs_pkg.sv]
// acs_pkg: shared constants, codes and types for the accelerometer step counter.
// Used by acs_cell, acs_chain, accel_step_counter_core and acs_checker.
// No dependencies.
package acs_pkg;

  // Default number of stamp cells in the chain
  localparam int STAMP_SLOTS_DEF = 20;

  // Field widths
  localparam int ACC_W    = 13;
  localparam int TIME_W   = 32;
  localparam int THR_W    = 12;
  localparam int IVL_W    = 16;
  localparam int WIN_W    = 20;
  localparam int TOTAL_W  = 24;
  localparam int PACE_W   = 2;
  localparam int RECENT_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // Squared widths
  localparam int SQ_W   = 25;  // one axis squared, at most 2^24
  localparam int MAG_W  = 26;  // sum of three squares
  localparam int THR2_W = 24;  // threshold squared

  // Counted steps saturate here
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Item op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // Pace codes
  localparam logic [PACE_W-1:0] PACE_IDLE = 2'd0;
  localparam logic [PACE_W-1:0] PACE_WALK = 2'd1;
  localparam logic [PACE_W-1:0] PACE_RUN  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_IVL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WALK_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd5;

  // Configuration reset values
  localparam logic [THR_W-1:0] THR_HIGH_RST = 12'd307;
  localparam logic [THR_W-1:0] THR_LOW_RST  = 12'd230;
  localparam logic [IVL_W-1:0] MIN_IVL_RST  = 16'd250;
  localparam logic [IVL_W-1:0] IDLE_LIM_RST = 16'd2000;
  localparam logic [IVL_W-1:0] WALK_LIM_RST = 16'd600;
  localparam logic [WIN_W-1:0] WINDOW_RST   = 20'd60000;

  // Popcount group size in the stamp chain
  localparam int GRP = 8;

  // Control from the sequencer to the stamp chain
  typedef struct packed {
    logic calc;   // evaluate window hits against the current time
    logic shift;  // push a new stamp into the head cell
    logic clear;  // empty every cell
  } acs_chain_ctrl_t;

endpackage

[hdl/acs_cell.sv]
// acs_cell: one stamp cell of the chain; holds a step time and flags it
// when it lies within the rate window. Depends on acs_pkg.
module acs_cell
  import acs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  acs_chain_ctrl_t       ctrl,
  input  logic [TIME_W-1:0]     stamp_in,
  input  logic [TIME_W-1:0]     now,
  input  logic [WIN_W-1:0]      window,
  output logic [TIME_W-1:0]     stamp_out,
  output logic                  hit
);

  logic [TIME_W-1:0] stamp_r;
  logic [TIME_W-1:0] stamp_nxt;
  logic [TIME_W-1:0] age;

  // Take the neighbor's stamp on a shift, empty on clear
  always_comb begin
    stamp_nxt = stamp_r;
    if (ctrl.clear) begin
      stamp_nxt = '0;
    end else if (ctrl.shift) begin
      stamp_nxt = stamp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r <= '0;
    end else begin
      stamp_r <= stamp_nxt;
    end
  end

  // Zero marks an empty cell; age is taken modulo 2^32
  assign age       = now - stamp_r;
  assign hit       = (stamp_r != '0) && (age <= {{(TIME_W-WIN_W){1'b0}}, window});
  assign stamp_out = stamp_r;

endmodule

[hdl/acs_chain.sv]
// acs_chain: row of acs_cell stamp cells plus the registered hit count
// that gives the number of recent steps. Depends on acs_pkg and acs_cell.
module acs_chain
  import acs_pkg::*;
#(
  parameter int STAMP_SLOTS = STAMP_SLOTS_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  acs_chain_ctrl_t        ctrl,
  input  logic [TIME_W-1:0]      now,
  input  logic [WIN_W-1:0]       window,
  output logic [RECENT_W-1:0]    recent
);

  localparam int CW = $clog2(STAMP_SLOTS + 1);
  localparam int RW = (CW > RECENT_W) ? CW : RECENT_W;
  localparam int NG = (STAMP_SLOTS + GRP - 1) / GRP;
  localparam int GW = $clog2(GRP + 1);

  logic [TIME_W-1:0] stamp_link [STAMP_SLOTS+1];
  logic              hit        [STAMP_SLOTS];
  logic [GW-1:0]     grp_r      [NG];
  logic [GW-1:0]     grp_nxt    [NG];
  logic              drop_hit_r;
  logic [RW-1:0]     base_cnt;
  logic [RW-1:0]     recent_full;

  // New stamp enters the head; the tail stamp falls off on a shift
  assign stamp_link[0] = now;

  for (genvar i = 0; i < STAMP_SLOTS; i++) begin : g_cell
    acs_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .stamp_in  (stamp_link[i]),
      .now       (now),
      .window    (window),
      .stamp_out (stamp_link[i+1]),
      .hit       (hit[i])
    );
  end

  // First level of the count: hits per group of cells
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < STAMP_SLOTS) begin
          grp_nxt[g] = grp_nxt[g] + GW'(hit[g * GRP + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      for (int g = 0; g < NG; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
      drop_hit_r <= hit[STAMP_SLOTS-1];
    end
  end

  // Second level: add the groups, then account for the stamp pushed in
  // and the one pushed out by a counted step
  always_comb begin
    base_cnt = '0;
    for (int g = 0; g < NG; g++) begin
      base_cnt = base_cnt + RW'(grp_r[g]);
    end
    recent_full = base_cnt;
    if (ctrl.shift) begin
      recent_full = base_cnt - RW'(drop_hit_r) + RW'(now != '0);
    end
  end

  assign recent = recent_full[RECENT_W-1:0];

endmodule

[hdl/accel_step_counter_core.sv]
// accel_step_counter_core: threshold/hysteresis step detector with pace class
// and a chain of stamp cells for recent-step counting. Depends on acs_pkg, acs_chain.
// An item passes the square/window stage, then the update stage, before its result is valid.
// The update stage takes the next item as it finishes; no item is taken during the square stage.
// A stalled result holds the update stage until out_ready, then the item moves on.
// Reset (synchronous, rst_n low): counters, stamps, arm flag and registers to defaults.
module accel_step_counter_core
  import acs_pkg::*;
#(
  parameter int STAMP_SLOTS = STAMP_SLOTS_DEF
)
(
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_wdata,
  // input items
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic signed [ACC_W-1:0]     in_accel_x,
  input  logic signed [ACC_W-1:0]     in_accel_y,
  input  logic signed [ACC_W-1:0]     in_accel_z,
  input  logic [TIME_W-1:0]           in_time_ms,
  // result items
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_step_detected,
  output logic [TOTAL_W-1:0]          out_total_steps,
  output logic [PACE_W-1:0]           out_pace,
  output logic [RECENT_W-1:0]         out_recent_steps
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  // Configuration registers
  logic [THR_W-1:0] thr_high_r;
  logic [THR_W-1:0] thr_low_r;
  logic [IVL_W-1:0] min_ivl_r;
  logic [IVL_W-1:0] idle_lim_r;
  logic [IVL_W-1:0] walk_lim_r;
  logic [WIN_W-1:0] window_r;

  // Sequencer and captured item
  logic [1:0]              state_r, state_nxt;
  logic                    op_r;
  logic signed [ACC_W-1:0] x_r, y_r, z_r;
  logic [TIME_W-1:0]       time_r;

  // Squares
  logic signed [2*ACC_W-1:0] sq_x_full, sq_y_full, sq_z_full;
  logic [2*THR_W-1:0]        hi2_full, lo2_full;
  logic [SQ_W-1:0]           sq_x_r, sq_y_r, sq_z_r;
  logic [THR2_W-1:0]         hi2_r, lo2_r;

  // Detector state
  logic               armed_r, armed_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TIME_W-1:0]  last_step_r, last_step_nxt;
  logic [PACE_W-1:0]  pace_r, pace_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                out_step_r;
  logic [TOTAL_W-1:0]  out_total_r;
  logic [PACE_W-1:0]   out_pace_r;
  logic [RECENT_W-1:0] out_recent_r;

  logic               accept, out_free, do_upd;
  logic [MAG_W-1:0]   mag2;
  logic [TIME_W-1:0]  interval;
  logic               arm_set, fire, counted;
  logic [RECENT_W-1:0] recent;
  acs_chain_ctrl_t    chain_ctrl;

  // Configuration writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_high_r <= THR_HIGH_RST;
      thr_low_r  <= THR_LOW_RST;
      min_ivl_r  <= MIN_IVL_RST;
      idle_lim_r <= IDLE_LIM_RST;
      walk_lim_r <= WALK_LIM_RST;
      window_r   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR_HIGH: thr_high_r <= cfg_wdata[THR_W-1:0];
        REG_THR_LOW:  thr_low_r  <= cfg_wdata[THR_W-1:0];
        REG_MIN_IVL:  min_ivl_r  <= cfg_wdata[IVL_W-1:0];
        REG_IDLE_LIM: idle_lim_r <= cfg_wdata[IVL_W-1:0];
        REG_WALK_LIM: walk_lim_r <= cfg_wdata[IVL_W-1:0];
        REG_WINDOW:   window_r   <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: a new item may enter while the update stage completes
  assign out_free = !out_valid_r || out_ready;
  assign do_upd   = (state_r == ST_UPD) && out_free;
  assign in_ready = (state_r == ST_IDLE) || do_upd;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_CALC;
      ST_CALC: state_nxt = ST_UPD;
      ST_UPD: begin
        if (do_upd) begin
          state_nxt = accept ? ST_CALC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      x_r    <= in_accel_x;
      y_r    <= in_accel_y;
      z_r    <= in_accel_z;
      time_r <= in_time_ms;
    end
  end

  // Square stage: axis squares and squared thresholds
  assign sq_x_full = (2*ACC_W)'(x_r) * (2*ACC_W)'(x_r);
  assign sq_y_full = (2*ACC_W)'(y_r) * (2*ACC_W)'(y_r);
  assign sq_z_full = (2*ACC_W)'(z_r) * (2*ACC_W)'(z_r);
  assign hi2_full  = (2*THR_W)'(thr_high_r) * (2*THR_W)'(thr_high_r);
  assign lo2_full  = (2*THR_W)'(thr_low_r) * (2*THR_W)'(thr_low_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_CALC) begin
      sq_x_r <= sq_x_full[SQ_W-1:0];
      sq_y_r <= sq_y_full[SQ_W-1:0];
      sq_z_r <= sq_z_full[SQ_W-1:0];
      hi2_r  <= hi2_full[THR2_W-1:0];
      lo2_r  <= lo2_full[THR2_W-1:0];
    end
  end

  // Update stage: hysteresis, interval gate, count and pace
  assign mag2 = MAG_W'(sq_x_r) + MAG_W'(sq_y_r) + MAG_W'(sq_z_r);
  assign interval = time_r - last_step_r;
  assign arm_set  = !armed_r && (mag2 > MAG_W'(hi2_r));
  assign fire     = armed_r && (mag2 < MAG_W'(lo2_r));
  assign counted  = fire && (interval >= TIME_W'(min_ivl_r));

  always_comb begin
    armed_nxt     = armed_r;
    total_nxt     = total_r;
    last_step_nxt = last_step_r;
    pace_nxt      = pace_r;
    if (op_r == OP_CLEAR) begin
      total_nxt     = '0;
      last_step_nxt = '0;
      pace_nxt      = PACE_IDLE;
    end else begin
      if (arm_set) begin
        armed_nxt = 1'b1;
      end else if (fire) begin
        armed_nxt = 1'b0;
      end
      if (counted) begin
        if (total_r != TOTAL_MAX) begin
          total_nxt = total_r + TOTAL_W'(1);
        end
        last_step_nxt = time_r;
        if (interval > TIME_W'(idle_lim_r)) begin
          pace_nxt = PACE_IDLE;
        end else if (interval > TIME_W'(walk_lim_r)) begin
          pace_nxt = PACE_WALK;
        end else begin
          pace_nxt = PACE_RUN;
        end
      end
      // a long gap forces idle whether or not a step counted
      if (interval > TIME_W'(idle_lim_r)) begin
        pace_nxt = PACE_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      total_r     <= '0;
      last_step_r <= '0;
      pace_r      <= PACE_IDLE;
    end else if (do_upd) begin
      armed_r     <= armed_nxt;
      total_r     <= total_nxt;
      last_step_r <= last_step_nxt;
      pace_r      <= pace_nxt;
    end
  end

  // Stamp chain
  always_comb begin
    chain_ctrl.calc  = (state_r == ST_CALC);
    chain_ctrl.shift = do_upd && (op_r == OP_SAMPLE) && counted;
    chain_ctrl.clear = do_upd && (op_r == OP_CLEAR);
  end

  acs_chain #(
    .STAMP_SLOTS (STAMP_SLOTS)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (chain_ctrl),
    .now    (time_r),
    .window (window_r),
    .recent (recent)
  );

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (do_upd) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_upd) begin
      out_step_r   <= (op_r == OP_SAMPLE) && counted;
      out_total_r  <= total_nxt;
      out_pace_r   <= pace_nxt;
      out_recent_r <= (op_r == OP_CLEAR) ? '0 : recent;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_step_detected = out_step_r;
  assign out_total_steps   = out_total_r;
  assign out_pace          = out_pace_r;
  assign out_recent_steps  = out_recent_r;

endmodule

[hdl/acs_checker.sv]
// acs_props: port-level assertions for accel_step_counter_core, bound to it below.
// Depends on acs_pkg and on the top level's port names.
module acs_props
  import acs_pkg::*;
#(
  parameter int STAMP_SLOTS = STAMP_SLOTS_DEF
)
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_step_detected,
  input logic [TOTAL_W-1:0]      out_total_steps,
  input logic [PACE_W-1:0]       out_pace,
  input logic [RECENT_W-1:0]     out_recent_steps
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_step_detected)
      && $stable(out_total_steps) && $stable(out_pace) && $stable(out_recent_steps))
    else $error("result changed while stalled");

  // The cycle after an item enters is the square stage, which takes nothing
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken during square stage");

  // A counted step never leaves the total at zero
  a_step_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_step_detected |-> out_total_steps != '0)
    else $error("step flagged with zero total");

  // The window count never exceeds the number of stamp cells
  a_recent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_recent_steps) <= 32'(STAMP_SLOTS)) || (STAMP_SLOTS > 31))
    else $error("recent count beyond stamp cells");

endmodule

bind accel_step_counter_core acs_props #(.STAMP_SLOTS(STAMP_SLOTS)) u_acs_props (.*);

[verif/acs_checker.sv]
`timescale 1ns / 1ps
// acs_checker: watches the config port and both item channels of the step counter,
// keeps its own copy of detector state, predicts every result and compares it.
// Depends on acs_pkg.
module acs_checker
  import acs_pkg::*;
#(
  parameter int STAMP_SLOTS = STAMP_SLOTS_DEF
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_op,
  input  logic signed [ACC_W-1:0] in_accel_x,
  input  logic signed [ACC_W-1:0] in_accel_y,
  input  logic signed [ACC_W-1:0] in_accel_z,
  input  logic [TIME_W-1:0]       in_time_ms,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    out_step_detected,
  input  logic [TOTAL_W-1:0]      out_total_steps,
  input  logic [PACE_W-1:0]       out_pace,
  input  logic [RECENT_W-1:0]     out_recent_steps,
  output int                      mismatches,
  output int                      outstanding,
  output int                      results_checked,
  output int                      steps_counted
);

  typedef struct packed {
    logic                step;
    logic [TOTAL_W-1:0]  total;
    logic [PACE_W-1:0]   pace;
    logic [RECENT_W-1:0] recent;
  } step_report_t;

  // Reports owed by the block, oldest first
  step_report_t report_q[$];

  // Register copies
  logic [THR_W-1:0] thr_high_r;
  logic [THR_W-1:0] thr_low_r;
  logic [IVL_W-1:0] min_ivl_r;
  logic [IVL_W-1:0] idle_lim_r;
  logic [IVL_W-1:0] walk_lim_r;
  logic [WIN_W-1:0] window_r;

  // Detector state copy
  logic               armed_r;
  logic [TOTAL_W-1:0] total_r;
  logic [TIME_W-1:0]  last_step_r;
  logic [PACE_W-1:0]  pace_r;
  logic [TIME_W-1:0]  stamps_r [STAMP_SLOTS];
  int unsigned        slot_r;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    results_checked = 0;
    steps_counted   = 0;
  end

  task automatic clear_counters();
    total_r     = '0;
    last_step_r = '0;
    pace_r      = PACE_IDLE;
    slot_r      = 0;
    for (int i = 0; i < STAMP_SLOTS; i++) stamps_r[i] = '0;
  endtask

  function automatic logic [PACE_W-1:0] pace_of(input logic [TIME_W-1:0] ivl);
    if (ivl > idle_lim_r) return PACE_IDLE;
    if (ivl > walk_lim_r) return PACE_WALK;
    return PACE_RUN;
  endfunction

  // Advance the state copy by one item and build the report it should produce
  task automatic track_item(input logic op, input logic signed [ACC_W-1:0] ax,
                            input logic signed [ACC_W-1:0] ay,
                            input logic signed [ACC_W-1:0] az,
                            input logic [TIME_W-1:0] now, output step_report_t rep);
    longint           mag2;
    longint           hi2;
    longint           lo2;
    logic [TIME_W-1:0] ivl;
    logic             fire;
    int               hits;
    rep = '0;
    if (op == OP_CLEAR) begin
      clear_counters();
    end else begin
      mag2 = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
           + longint'(az) * longint'(az);
      hi2  = longint'(thr_high_r) * longint'(thr_high_r);
      lo2  = longint'(thr_low_r) * longint'(thr_low_r);
      ivl  = now - last_step_r;
      fire = 1'b0;
      // hysteresis: arm strictly above high, fire strictly below low
      if (!armed_r && mag2 > hi2) begin
        armed_r = 1'b1;
      end else if (armed_r && mag2 < lo2) begin
        fire    = 1'b1;
        armed_r = 1'b0;
      end
      if (fire && ivl >= min_ivl_r) begin
        rep.step = 1'b1;
        if (total_r != TOTAL_MAX) total_r = total_r + 1'b1;
        last_step_r = now;
        if (slot_r >= STAMP_SLOTS) slot_r = 0;
        stamps_r[slot_r] = now;
        slot_r = (slot_r + 1) % STAMP_SLOTS;
        pace_r = pace_of(ivl);
      end
      if (ivl > idle_lim_r) pace_r = PACE_IDLE;
    end
    // zero stamps read as empty slots
    hits = 0;
    for (int i = 0; i < STAMP_SLOTS; i++) begin
      if (stamps_r[i] != '0 && TIME_W'(now - stamps_r[i]) <= window_r) hits++;
    end
    rep.total  = total_r;
    rep.pace   = pace_r;
    rep.recent = hits[RECENT_W-1:0];
  endtask

  // Sample everything at the edge; results are checked before new items are queued
  always @(posedge clk) begin
    step_report_t got;
    step_report_t want;
    if (!rst_n) begin
      thr_high_r = THR_HIGH_RST;
      thr_low_r  = THR_LOW_RST;
      min_ivl_r  = MIN_IVL_RST;
      idle_lim_r = IDLE_LIM_RST;
      walk_lim_r = WALK_LIM_RST;
      window_r   = WINDOW_RST;
      armed_r    = 1'b0;
      clear_counters();
      report_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THR_HIGH: thr_high_r = cfg_wdata[THR_W-1:0];
          REG_THR_LOW:  thr_low_r  = cfg_wdata[THR_W-1:0];
          REG_MIN_IVL:  min_ivl_r  = cfg_wdata[IVL_W-1:0];
          REG_IDLE_LIM: idle_lim_r = cfg_wdata[IVL_W-1:0];
          REG_WALK_LIM: walk_lim_r = cfg_wdata[IVL_W-1:0];
          REG_WINDOW:   window_r   = cfg_wdata[WIN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = '{out_step_detected, out_total_steps, out_pace, out_recent_steps};
        results_checked++;
        if (report_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no item pending: step %0b total %0d pace %0d recent %0d",
                     $realtime, got.step, got.total, got.pace, got.recent);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          if (got.step !== want.step || got.total !== want.total ||
              got.pace !== want.pace || got.recent !== want.recent) begin
            if (mismatches < 10)
              $display("%0t: result %0d differs (exp/got): step %0b/%0b total %0d/%0d pace %0d/%0d recent %0d/%0d",
                       $realtime, results_checked, want.step, got.step, want.total,
                       got.total, want.pace, got.pace, want.recent, got.recent);
            mismatches++;
          end
        end
      end

      if (in_valid && in_ready) begin
        track_item(in_op, in_accel_x, in_accel_y, in_accel_z, in_time_ms, want);
        report_q.push_back(want);
        if (want.step) steps_counted++;
      end
    end
    outstanding = report_q.size();
  end

endmodule

[verif/accel_step_counter_core_tb.sv]
`timescale 1ns / 1ps
// accel_step_counter_core_tb: drives samples, clears and register settings into the
// step counter with random idling on both sides; acs_checker checks every result.
// Depends on acs_pkg, accel_step_counter_core, acs_checker.
module accel_step_counter_core_tb;
  import acs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  // indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;
  logic                    in_valid   = 1'b0;
  logic                    in_op      = OP_SAMPLE;
  logic signed [ACC_W-1:0] in_accel_x = '0;
  logic signed [ACC_W-1:0] in_accel_y = '0;
  logic signed [ACC_W-1:0] in_accel_z = '0;
  logic [TIME_W-1:0]       in_time_ms = '0;
  logic                    out_ready  = 1'b0;
  logic                    in_ready;
  logic                    out_valid;
  logic                    out_step_detected;
  logic [TOTAL_W-1:0]      out_total_steps;
  logic [PACE_W-1:0]       out_pace;
  logic [RECENT_W-1:0]     out_recent_steps;

  int mismatches;
  int outstanding;
  int results_checked;
  int steps_counted;

  int send_idle_pct = 27;
  int recv_idle_pct = 63;
  int stall_reqs    = 0;
  int stall_seen    = 0;
  int items_sent    = 0;
  int setting_count = 1;
  int cycle_count   = 0;

  // current register values, used to aim sample timing at the pace limits
  int unsigned cur_thr_h = THR_HIGH_RST;
  int unsigned cur_thr_l = THR_LOW_RST;
  int unsigned cur_min   = MIN_IVL_RST;
  int unsigned cur_idle  = IDLE_LIM_RST;
  int unsigned cur_walk  = WALK_LIM_RST;

  logic [TIME_W-1:0] now_ms    = '0;
  logic              want_high = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  accel_step_counter_core uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_step_detected(out_step_detected), .out_total_steps(out_total_steps),
    .out_pace(out_pace), .out_recent_steps(out_recent_steps)
  );

  acs_checker u_check (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_step_detected(out_step_detected), .out_total_steps(out_total_steps),
    .out_pace(out_pace), .out_recent_steps(out_recent_steps),
    .mismatches(mismatches), .outstanding(outstanding),
    .results_checked(results_checked), .steps_counted(steps_counted)
  );

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (stall_reqs != stall_seen) begin
        stall_seen = stall_reqs;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one item; returns at the edge where it is accepted, valid still high
  task automatic send_item(input logic op, input logic signed [ACC_W-1:0] ax,
                           input logic signed [ACC_W-1:0] ay,
                           input logic signed [ACC_W-1:0] az,
                           input logic [TIME_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_accel_x <= ax;
    in_accel_y <= ay;
    in_accel_z <= az;
    in_time_ms <= t;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Stop offering and wait for every owed result
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] thr_h,
                              input logic [CFG_DATA_W-1:0] thr_l,
                              input logic [CFG_DATA_W-1:0] min_ivl,
                              input logic [CFG_DATA_W-1:0] idle_lim,
                              input logic [CFG_DATA_W-1:0] walk_lim,
                              input logic [CFG_DATA_W-1:0] window);
    write_reg(REG_THR_HIGH, thr_h);
    write_reg(REG_THR_LOW, thr_l);
    write_reg(REG_MIN_IVL, min_ivl);
    write_reg(REG_IDLE_LIM, idle_lim);
    write_reg(REG_WALK_LIM, walk_lim);
    write_reg(REG_WINDOW, window);
    cfg_we    <= 1'b0;
    cur_thr_h = thr_h[THR_W-1:0];
    cur_thr_l = thr_l[THR_W-1:0];
    cur_min   = min_ivl[IVL_W-1:0];
    cur_idle  = idle_lim[IVL_W-1:0];
    cur_walk  = walk_lim[IVL_W-1:0];
    setting_count++;
  endtask

  function automatic logic signed [ACC_W-1:0] signed_axis(input int unsigned mag);
    logic [ACC_W-1:0] m;
    m = ACC_W'(mag);
    return $urandom_range(1) ? -m : m;
  endfunction

  // Time step between samples; two of these make one step interval
  function automatic int unsigned pick_gap();
    case ($urandom_range(19))
      0, 1, 2, 3:    return $urandom_range(0, 5);
      4, 5, 6:       return $urandom_range(0, cur_min) / 2;
      7:             return (cur_min + $urandom_range(0, 2)) / 2;
      8, 9, 10, 11, 12: return $urandom_range(cur_min, cur_walk) / 2;
      13, 14, 15:    return $urandom_range(cur_walk, cur_idle) / 2;
      16, 17:        return $urandom_range(cur_idle, cur_idle + 200) / 2;
      18:            return $urandom_range(0, 400);
      default:       return $urandom_range(20000, 200000);
    endcase
  endfunction

  // Mostly alternating arm/fire samples, some noise, the odd clear
  task automatic send_random_item();
    int unsigned       r;
    int unsigned       a;
    logic signed [ACC_W-1:0] ax;
    logic signed [ACC_W-1:0] ay;
    logic signed [ACC_W-1:0] az;
    r = $urandom_range(99);
    if (r < 3) begin
      now_ms = now_ms + pick_gap();
      send_item(OP_CLEAR, ACC_W'($urandom), ACC_W'($urandom), ACC_W'($urandom), now_ms);
    end else if (r < 15) begin
      if ($urandom_range(3) == 0) now_ms = $urandom;
      else now_ms = now_ms + pick_gap();
      send_item(OP_SAMPLE, ACC_W'($urandom), ACC_W'($urandom), ACC_W'($urandom), now_ms);
    end else begin
      if (want_high) begin
        a = cur_thr_h + $urandom_range(1, 400);
        if (a > 4095) a = 4095;
        ax = signed_axis($urandom_range(0, a / 4));
        ay = signed_axis($urandom_range(0, a / 4));
        az = signed_axis(a);
      end else begin
        ax = signed_axis($urandom_range(0, cur_thr_l / 2));
        ay = signed_axis($urandom_range(0, cur_thr_l / 2));
        az = signed_axis($urandom_range(0, cur_thr_l / 2));
      end
      if ($urandom_range(9) != 0) want_high = !want_high;
      now_ms = now_ms + pick_gap();
      send_item(OP_SAMPLE, ax, ay, az, now_ms);
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_item();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset register values: 307/230, min 250, idle 2000, walk 600
    send_item(OP_SAMPLE, 0, 0, 0, 100);             // low while unarmed
    send_item(OP_SAMPLE, 0, 0, 4095, 200);          // arm, max positive
    send_item(OP_SAMPLE, -4096, -4096, -4096, 300); // max negative, stays armed
    send_item(OP_SAMPLE, 0, 0, 0, 400);             // fire, run pace
    send_item(OP_SAMPLE, 0, 0, 307, 500);           // equal to high: no arm
    send_item(OP_SAMPLE, 0, 0, -100, 600);          // low, unarmed
    send_item(OP_SAMPLE, 0, 0, 308, 700);           // arm
    send_item(OP_SAMPLE, 0, 0, 230, 1000);          // equal to low: no fire
    send_item(OP_SAMPLE, 0, -229, 0, 1100);         // fire, walk pace
    send_item(OP_SAMPLE, 0, 0, 500, 1200);          // arm
    send_item(OP_SAMPLE, 0, 0, 0, 1300);            // fire too soon, not counted
    send_item(OP_SAMPLE, 0, 0, 500, 1340);          // arm
    send_item(OP_SAMPLE, 0, 0, 0, 1350);            // interval exactly the minimum
    send_item(OP_SAMPLE, 0, 0, 0, 4000);            // long quiet: pace forced idle
    send_item(OP_SAMPLE, 300, 300, 300, 5000);      // arm from three axes
    send_item(OP_SAMPLE, 0, 0, 0, 7000);            // counted with idle pace
    send_item(OP_SAMPLE, 0, 0, -4096, 7200);        // arm
    send_item(OP_CLEAR, 1234, -777, 4095, 7300);    // clear keeps the arm flag
    send_item(OP_SAMPLE, 10, 10, 10, 7400);         // fires from the kept arm
    send_item(OP_SAMPLE, 0, 4095, 0, 32'hFFFF_FE0C);
    send_item(OP_SAMPLE, 0, 0, 0, 32'hFFFF_FE70);   // step near time wrap
    send_item(OP_SAMPLE, 0, 0, 4095, 32'hFFFF_FFFF);
    send_item(OP_SAMPLE, 0, 0, 0, 32'h0000_0000);   // step at time zero, reads empty
    send_item(OP_SAMPLE, 0, 0, 0, 32'h0000_0000);
    now_ms = 32'd1000;

    // Typical settings, with a long result stall and a full pause
    wait_results_drained();
    apply_config(CFG_DATA_W'(300 + $urandom_range(200)),
                 CFG_DATA_W'(150 + $urandom_range(150)),
                 CFG_DATA_W'(200 + $urandom_range(100)),
                 CFG_DATA_W'(1500 + $urandom_range(1000)),
                 CFG_DATA_W'(500 + $urandom_range(300)),
                 CFG_DATA_W'(20000 + $urandom_range(60000)));
    run_random(100);
    stall_reqs++;
    send_idle_pct = 0;
    run_random(30);
    send_idle_pct = 27;
    wait_results_drained();
    run_random(100);

    // Lowest register values, low threshold above high
    send_idle_pct = 63;
    recv_idle_pct = 27;
    wait_results_drained();
    apply_config(0, 4095, 0, 0, 0, 0);
    run_random(120);

    // Highest register values
    wait_results_drained();
    apply_config(4095, 4095, 65535, 65535, 65535, 20'hFFFFF);
    run_random(120);

    // Random settings with junk above the register widths, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_results_drained();
    write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
    apply_config({8'($urandom), 12'(250 + $urandom_range(400))},
                 {8'($urandom), 12'(100 + $urandom_range(200))},
                 {4'($urandom), 16'($urandom_range(100, 400))},
                 {4'($urandom), 16'($urandom_range(1000, 4000))},
                 {4'($urandom), 16'($urandom_range(300, 1200))},
                 20'($urandom_range(1000, 300000)));
    run_random(230);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d items over %0d register settings", items_sent, setting_count);
    $display("%0d results checked, %0d steps counted", results_checked, steps_counted);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[accel_step_counter_core.f]
hdl/acs_pkg.sv
hdl/acs_cell.sv
hdl/acs_chain.sv
hdl/accel_step_counter_core.sv
hdl/acs_checker.sv
verif/acs_checker.sv
verif/accel_step_counter_core_tb.sv
